[rtl/sha1md_pkg.sv]
// ----------------------------------------------------------------------------
// sha1md_pkg
// Types, constants and round functions shared by the SHA-1 digest unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1md_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumH    = 5;
  localparam int unsigned BlkWrds = 16;
  localparam int unsigned Rounds  = 80;

  localparam logic [2:0] MaxBytes = 3'd4;
  localparam logic [3:0] LenSlot  = 4'd14;   // word slot where the length starts
  localparam logic [3:0] LastSlot = 4'd15;
  localparam logic [6:0] LastRnd  = 7'(Rounds - 1);
  localparam logic [2:0] LastIdx  = 3'(NumH - 1);

  localparam logic [WordW-1:0] PadByte = 32'h8000_0000;

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumH-1:0][WordW-1:0] hash_t;

  localparam hash_t InitVec = {32'hc3d2_e1f0, 32'h1032_5476, 32'h98ba_dcfe,
                               32'hefcd_ab89, 32'h6745_2301};

  // input and output transactions
  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  bytes_valid;
    logic        end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // controls between sequencer, schedule and round unit
  typedef struct packed {
    logic push;
    logic step;
  } sched_ctl_t;

  typedef struct packed {
    logic start;
    logic load_iv;
  } core_ctl_t;

  typedef struct packed {
    logic step;
    logic done;
  } core_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD80,
    ST_PADZ,
    ST_LENHI,
    ST_LENLO,
    ST_OUT
  } seq_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RUN,
    CS_FIN
  } core_state_e;

  // round constant by round number
  function automatic word_t round_k(input logic [6:0] rnd);
    word_t k;
    if (rnd < 7'd20) begin
      k = 32'h5a82_7999;
    end else if (rnd < 7'd40) begin
      k = 32'h6ed9_eba1;
    end else if (rnd < 7'd60) begin
      k = 32'h8f1b_bcdc;
    end else begin
      k = 32'hca62_c1d6;
    end
    return k;
  endfunction

  // round logic function by round number
  function automatic word_t round_f(input logic [6:0] rnd, input word_t b,
                                    input word_t c, input word_t d);
    word_t f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd >= 7'd40 && rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

[rtl/sha1md_sched.sv]
// ----------------------------------------------------------------------------
// sha1md_sched
// Sixteen-word shift line: loads message words, then expands the schedule
// one word per round.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_sched import sha1md_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  sched_ctl_t ctl_i,
  input  word_t      data_i,
  output word_t      w_o
);

  word_t w_q [BlkWrds];
  word_t exp_w;
  word_t x;

  // next schedule word from the fixed taps
  assign x     = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign exp_w = {x[30:0], x[31]};
  assign w_o   = w_q[0];

  // shift line, newest word at the top
  always_ff @(posedge clk_i) begin
    if (ctl_i.push || ctl_i.step) begin
      for (int i = 0; i < BlkWrds - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[BlkWrds-1] <= ctl_i.push ? data_i : exp_w;
    end
  end

  // rst_ni kept for port uniformity; the line holds payload only
  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

`default_nettype wire

[rtl/sha1md_core.sv]
// ----------------------------------------------------------------------------
// sha1md_core
// Shared round unit: one SHA-1 round per cycle for all 80 rounds, then the
// chaining words are updated.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_core import sha1md_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  core_ctl_t  ctl_i,
  input  word_t      w_i,
  output core_stat_t stat_o,
  output hash_t      h_o
);

  core_state_e state_q, state_d;
  logic [6:0]  rnd_q, rnd_d;
  hash_t       h_q, h_d;
  word_t       a_q, b_q, c_q, d_q, e_q;
  word_t       t;

  // round sum
  assign t = {a_q[26:0], a_q[31:27]} + round_f(rnd_q, b_q, c_q, d_q) + e_q +
             round_k(rnd_q) + w_i;

  assign h_o = h_q;

  // sequencer for one block
  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    h_d         = h_q;
    stat_o.step = 1'b0;
    stat_o.done = 1'b0;
    case (state_q)
      CS_IDLE: begin
        if (ctl_i.load_iv) begin
          h_d = InitVec;
        end
        if (ctl_i.start) begin
          rnd_d   = '0;
          state_d = CS_RUN;
        end
      end
      CS_RUN: begin
        stat_o.step = 1'b1;
        if (rnd_q == LastRnd) begin
          rnd_d   = '0;
          state_d = CS_FIN;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      CS_FIN: begin
        stat_o.done = 1'b1;
        h_d[0]      = h_q[0] + a_q;
        h_d[1]      = h_q[1] + b_q;
        h_d[2]      = h_q[2] + c_q;
        h_d[3]      = h_q[3] + d_q;
        h_d[4]      = h_q[4] + e_q;
        state_d     = CS_IDLE;
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      rnd_q   <= '0;
      h_q     <= InitVec;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      h_q     <= h_d;
    end
  end

  // working words
  always_ff @(posedge clk_i) begin
    if (state_q == CS_IDLE && ctl_i.start) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (state_q == CS_RUN) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

endmodule

`default_nettype wire

[rtl/sha1_message_digest_unit.sv]
// ----------------------------------------------------------------------------
// sha1_message_digest_unit
// SHA-1 over a byte-packed word stream: packs bytes into block words, pads
// at end of message and streams out the five digest words.
// ----------------------------------------------------------------------------
// throughput: words that fill no block are taken one per cycle while idle
// a word that fills a 64-byte block holds the input through the accept with
//   load, 80 rounds in the shared round unit and the chaining update
// end of message: padding and length words, a wait in ST_COMP for each
//   of one or two compressions, then five digest words at one per ready cycle
// reset: initial vector, byte and length counts clear; no block buffer reset
`default_nettype none

module sha1_message_digest_unit import sha1md_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output out_item_t  out_o
);

  seq_state_e  state_q, state_d, ret_q, ret_d, after;
  logic [31:0] pw_q, pw_d;         // partial word, left aligned
  logic [1:0]  pb_q, pb_d;         // bytes in partial word
  logic [3:0]  wc_q, wc_d;         // words in block
  logic [63:0] len_q, len_d;
  logic [2:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        accept;
  logic [2:0]  nbytes;
  logic [31:0] msg_m;
  logic [63:0] merged;
  logic [2:0]  total;
  logic        push;
  word_t       push_data;

  sched_ctl_t  sched_ctl;
  core_ctl_t   core_ctl;
  core_stat_t  core_stat;
  word_t       w_cur;
  hash_t       h_cur;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // byte packing of the incoming transaction
  assign nbytes = (in_i.bytes_valid > MaxBytes) ? MaxBytes : in_i.bytes_valid;
  assign msg_m  = in_i.message_word & ~(32'hFFFF_FFFF >> {nbytes, 3'b000});
  assign merged = {pw_q, 32'h0} | ({msg_m, 32'h0} >> {pb_q, 3'b000});
  assign total  = {1'b0, pb_q} + nbytes;

  // sequencer
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    pw_d        = pw_q;
    pb_d        = pb_q;
    wc_d        = wc_q;
    len_d       = len_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    push        = 1'b0;
    push_data   = '0;
    after       = state_q;
    core_ctl    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          len_d = len_q + 64'({nbytes, 3'b000});
          after = in_i.end_of_message ? ST_PAD80 : ST_IDLE;
          if (total >= MaxBytes) begin
            push      = 1'b1;
            push_data = merged[63:32];
            pw_d      = merged[31:0];
            pb_d      = 2'(total - MaxBytes);
          end else begin
            pw_d = merged[63:32];
            pb_d = total[1:0];
          end
        end
      end
      ST_COMP: begin
        if (core_stat.done) begin
          state_d = ret_q;
        end
      end
      ST_PAD80: begin
        push      = 1'b1;
        push_data = pw_q | (PadByte >> {pb_q, 3'b000});
        pw_d      = '0;
        pb_d      = '0;
        after     = ST_PADZ;
      end
      ST_PADZ: begin
        if (wc_q == LenSlot) begin
          after = ST_LENHI;
        end else begin
          push  = 1'b1;
          after = ST_PADZ;
        end
      end
      ST_LENHI: begin
        push      = 1'b1;
        push_data = len_q[63:32];
        after     = ST_LENLO;
      end
      ST_LENLO: begin
        push      = 1'b1;
        push_data = len_q[31:0];
        after     = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.digest_word = h_cur[idx_q];
          out_d.word_index  = idx_q;
          out_d.last_word   = (idx_q == LastIdx);
          if (idx_q == LastIdx) begin
            idx_d            = '0;
            len_d            = '0;
            core_ctl.load_iv = 1'b1;
            state_d          = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // word push into the schedule; a full block starts compression
    if (state_q != ST_COMP && state_q != ST_OUT) begin
      state_d = after;
      if (push) begin
        wc_d = wc_q + 4'd1;
        if (wc_q == LastSlot) begin
          core_ctl.start = 1'b1;
          ret_d          = after;
          state_d        = ST_COMP;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      pw_q        <= '0;
      pb_q        <= '0;
      wc_q        <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      pw_q        <= pw_d;
      pb_q        <= pb_d;
      wc_q        <= wc_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign sched_ctl.push = push;
  assign sched_ctl.step = core_stat.step;

  sha1md_sched u_sched (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sched_ctl),
    .data_i (push_data),
    .w_o    (w_cur)
  );

  sha1md_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (core_ctl),
    .w_i    (w_cur),
    .stat_o (core_stat),
    .h_o    (h_cur)
  );

  // no word enters the schedule while rounds are running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sched_ctl.push |-> !core_stat.step)
    else $error("schedule push during rounds");

  // the low length word always closes a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LENLO |-> wc_q == LastSlot)
    else $error("length word not in last slot");

  // digest readout starts from an empty block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |-> (wc_q == 4'd0 && pb_q == 2'd0))
    else $error("block not empty at digest readout");

  // compression finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.done |-> state_q == ST_COMP)
    else $error("compression done outside wait state");

  // a started compression is reported done after the round pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_ctl.start |-> ##81 core_stat.done)
    else $error("compression length mismatch");

endmodule

`default_nettype wire
